// ----- src/range_minimum_query_assert.svh -----
// ---------------------------------------------------------------------------
// Range minimum query: assertion macros
// Implication checks on the block clock, held off during reset.
// ---------------------------------------------------------------------------
`ifndef RANGE_MINIMUM_QUERY_ASSERT_SVH
`define RANGE_MINIMUM_QUERY_ASSERT_SVH

// same-cycle implication
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rmq assertion failed");

// next-cycle implication
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rmq assertion failed");

`endif

// ----- src/rmq_pkg.sv -----
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared types, codes and defaults of the range minimum query block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;
    localparam int VALUE_WIDTH_DEF  = 32;
    localparam int CFG_W            = 11;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_NOBLD = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [9:0]         first_index;
        logic [9:0]         second_index;
        logic signed [31:0] load_value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] min_value;
        logic [9:0]         min_position;
        logic [1:0]         status;
    } rsp_t;

    typedef enum logic [5:0] {
        C_NOP, C_TAKE, C_LOAD, C_BINIT,
        C_TRD, C_TVI, C_TCHK, C_TPRD, C_TLINK, C_TPUSH,
        C_A0RD, C_A0WR, C_AJRD1, C_AJRD2, C_AJWR,
        C_DINIT, C_DRD, C_DSTEP, C_DWR,
        C_QCHK, C_QDA, C_QDB, C_QUP, C_QUPW, C_QEQ,
        C_QLU, C_QLV, C_QLC, C_QLP, C_QLR, C_QVAL, C_QVW,
        C_OUT
    } cmd_t;

    typedef struct packed {
        logic built;
        logic pop_go;
        logic i_last;
        logic lvl_last;
        logic lvl_zero;
        logic a_no;
        logic bad;
        logic diff_bit;
        logic uv_eq;
    } stat_t;

endpackage

// ----- src/rmq_dpath.sv -----
// ---------------------------------------------------------------------------
// rmq_dpath
// Stores, Cartesian tree stack, ancestor table and query walk registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_dpath #(
    parameter int MAX_ELEMENTS = rmq_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = rmq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  rmq_pkg::cmd_t             cmd,
    input  rmq_pkg::req_t             req,
    input  logic                      cfg_we,
    input  logic [rmq_pkg::CFG_W-1:0] cfg_data,
    output rmq_pkg::stat_t            stat,
    output rmq_pkg::rsp_t             rsp
);
    import rmq_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int NW    = IDX_W + 1;
    localparam int LV    = IDX_W + 1;
    localparam int LW    = $clog2(LV);
    localparam int AD    = MAX_ELEMENTS * LV;
    localparam int AW    = $clog2(AD);
    localparam int SW    = IDX_W + VALUE_WIDTH;
    localparam logic [NW-1:0] NO_NODE = '1;

    function automatic logic [AW-1:0] aaddr(input logic [LW-1:0] l,
                                            input logic [IDX_W-1:0] n);
        return AW'(l) * AW'(MAX_ELEMENTS) + AW'(n);
    endfunction

    logic signed [VALUE_WIDTH-1:0] vmem [MAX_ELEMENTS];
    logic [NW-1:0]                 pmem [MAX_ELEMENTS];
    logic [IDX_W-1:0]              dmem [MAX_ELEMENTS];
    logic [NW-1:0]                 amem [AD];
    logic [SW-1:0]                 smem [MAX_ELEMENTS];

    logic signed [VALUE_WIDTH-1:0] vq_reg;
    logic [NW-1:0]                 pq_reg;
    logic [IDX_W-1:0]              dq_reg;
    logic [NW-1:0]                 aq_reg;
    logic [SW-1:0]                 sq_reg;

    logic                          built_reg;
    logic [CW-1:0]                 ec_reg;
    req_t                          item_reg;
    logic [IDX_W-1:0]              i_reg;
    logic [CW-1:0]                 sp_reg;
    logic [LW-1:0]                 lvl_reg;
    logic [IDX_W-1:0]              top_idx_reg;
    logic signed [VALUE_WIDTH-1:0] top_val_reg;
    logic signed [VALUE_WIDTH-1:0] vi_reg;
    logic [NW-1:0]                 last_reg;
    logic [NW-1:0]                 u_reg;
    logic [NW-1:0]                 v_reg;
    logic [NW-1:0]                 au_reg;
    logic [NW-1:0]                 res_reg;
    logic [IDX_W-1:0]              d_reg;
    logic [IDX_W-1:0]              du_reg;
    logic [IDX_W:0]                diff_reg;
    logic signed [31:0]            rv_reg;
    logic [9:0]                    rp_reg;
    logic [1:0]                    rs_reg;
    rsp_t                          rsp_reg;

    logic                          v_re, v_we, p_re, p_we, d_re, d_we, a_re, a_we, s_re, s_we;
    logic [IDX_W-1:0]              v_raddr, v_waddr, p_raddr, p_waddr, d_raddr, d_waddr;
    logic [IDX_W-1:0]              s_raddr, s_waddr;
    logic [AW-1:0]                 a_raddr, a_waddr;
    logic signed [VALUE_WIDTH-1:0] v_wdata;
    logic [NW-1:0]                 p_wdata, a_wdata;
    logic [CW-1:0]                 sp_m1, sp_m2;
    logic [LW-1:0]                 lvl_m1;
    logic [CW-1:0]                 ec_next;
    logic                          a_ok, load_ok;

    assign sp_m1  = sp_reg - CW'(1);
    assign sp_m2  = sp_reg - CW'(2);
    assign lvl_m1 = lvl_reg - LW'(1);

    assign load_ok = 32'(item_reg.first_index) < 32'(MAX_ELEMENTS);

    assign stat.built    = built_reg;
    assign stat.pop_go   = (sp_reg != '0) && (top_val_reg > vi_reg);
    assign stat.i_last   = CW'(i_reg) == (ec_reg - CW'(1));
    assign stat.lvl_last = lvl_reg == LW'(LV - 1);
    assign stat.lvl_zero = lvl_reg == '0;
    assign stat.a_no     = aq_reg == NO_NODE;
    assign stat.bad      = (32'(item_reg.first_index) >= 32'(ec_reg))
                        || (32'(item_reg.second_index) >= 32'(ec_reg));
    assign stat.diff_bit = diff_reg[lvl_reg];
    assign stat.uv_eq    = u_reg == v_reg;
    assign a_ok          = !stat.built || stat.bad;

    assign rsp = rsp_reg;

    always_comb
    begin
        if (cfg_data == '0)
            ec_next = CW'(1);
        else if (32'(cfg_data) > 32'(MAX_ELEMENTS))
            ec_next = CW'(MAX_ELEMENTS);
        else
            ec_next = CW'(cfg_data);
    end

    always_comb
    begin
        v_re = 1'b0; v_we = 1'b0; p_re = 1'b0; p_we = 1'b0; d_re = 1'b0; d_we = 1'b0;
        a_re = 1'b0; a_we = 1'b0; s_re = 1'b0; s_we = 1'b0;
        v_raddr = i_reg;
        v_waddr = item_reg.first_index[IDX_W-1:0];
        v_wdata = VALUE_WIDTH'(item_reg.load_value);
        p_raddr = i_reg;
        p_waddr = i_reg;
        p_wdata = NO_NODE;
        d_raddr = item_reg.first_index[IDX_W-1:0];
        d_waddr = i_reg;
        a_raddr = aaddr(lvl_reg, u_reg[IDX_W-1:0]);
        a_waddr = aaddr(lvl_reg, i_reg);
        a_wdata = aq_reg;
        s_raddr = sp_m2[IDX_W-1:0];
        s_waddr = sp_m1[IDX_W-1:0];
        case (cmd)
            C_LOAD:  v_we = load_ok;
            C_TRD:   v_re = 1'b1;
            C_TCHK:  s_re = stat.pop_go;
            C_TLINK:
            begin
                p_we    = 1'b1;
                p_wdata = (sp_reg != '0) ? NW'(top_idx_reg) : NO_NODE;
            end
            C_TPUSH:
            begin
                p_we    = last_reg != NO_NODE;
                p_waddr = last_reg[IDX_W-1:0];
                p_wdata = NW'(i_reg);
                s_we    = sp_reg != '0;
            end
            C_A0RD:  p_re = 1'b1;
            C_A0WR:
            begin
                a_we    = 1'b1;
                a_wdata = pq_reg;
            end
            C_AJRD1:
            begin
                a_re    = 1'b1;
                a_raddr = aaddr(lvl_m1, i_reg);
            end
            C_AJRD2:
            begin
                a_re    = !stat.a_no;
                a_raddr = aaddr(lvl_m1, aq_reg[IDX_W-1:0]);
                a_we    = stat.a_no;
                a_wdata = NO_NODE;
            end
            C_AJWR:  a_we = 1'b1;
            C_DRD:   a_re = 1'b1;
            C_DWR:   d_we = 1'b1;
            C_QCHK:  d_re = !a_ok;
            C_QDA:
            begin
                d_re    = 1'b1;
                d_raddr = item_reg.second_index[IDX_W-1:0];
            end
            C_QUP:   a_re = stat.diff_bit;
            C_QLU:   a_re = 1'b1;
            C_QLV:
            begin
                a_re    = 1'b1;
                a_raddr = aaddr(lvl_reg, v_reg[IDX_W-1:0]);
            end
            C_QLP:
            begin
                a_re    = 1'b1;
                a_raddr = aaddr('0, u_reg[IDX_W-1:0]);
            end
            C_QVAL:
            begin
                v_re    = 1'b1;
                v_raddr = res_reg[IDX_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[v_waddr] <= v_wdata;
        if (v_re)
            vq_reg <= vmem[v_raddr];
        if (p_we)
            pmem[p_waddr] <= p_wdata;
        if (p_re)
            pq_reg <= pmem[p_raddr];
        if (d_we)
            dmem[d_waddr] <= d_reg;
        if (d_re)
            dq_reg <= dmem[d_raddr];
        if (a_we)
            amem[a_waddr] <= a_wdata;
        if (a_re)
            aq_reg <= amem[a_raddr];
        if (s_we)
            smem[s_waddr] <= {top_idx_reg, top_val_reg};
        if (s_re)
            sq_reg <= smem[s_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            built_reg <= 1'b0;
            ec_reg    <= CW'(MAX_ELEMENTS);
        end
        else
        begin
            if (cfg_we)
            begin
                ec_reg    <= ec_next;
                built_reg <= 1'b0;
            end
            else if (cmd == C_LOAD && load_ok)
                built_reg <= 1'b0;
            else if (cmd == C_DWR && stat.i_last)
                built_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            C_TAKE:
            begin
                item_reg <= req;
                rv_reg   <= '0;
                rp_reg   <= '0;
                rs_reg   <= STAT_OK;
            end
            C_LOAD:
                if (!load_ok)
                    rs_reg <= STAT_RANGE;
            C_BINIT:
            begin
                i_reg   <= '0;
                sp_reg  <= '0;
                lvl_reg <= '0;
            end
            C_TVI:
            begin
                vi_reg   <= vq_reg;
                last_reg <= NO_NODE;
            end
            C_TCHK:
                if (stat.pop_go)
                begin
                    last_reg <= NW'(top_idx_reg);
                    sp_reg   <= sp_m1;
                end
            C_TPRD:
                if (sp_reg != '0)
                    {top_idx_reg, top_val_reg} <= sq_reg;
            C_TPUSH:
            begin
                top_idx_reg <= i_reg;
                top_val_reg <= vi_reg;
                sp_reg      <= sp_reg + CW'(1);
                i_reg       <= stat.i_last ? '0 : i_reg + IDX_W'(1);
            end
            C_A0WR:
            begin
                i_reg <= stat.i_last ? '0 : i_reg + IDX_W'(1);
                if (stat.i_last)
                    lvl_reg <= LW'(1);
            end
            C_AJRD2, C_AJWR:
                if ((cmd == C_AJWR) || stat.a_no)
                begin
                    i_reg <= stat.i_last ? '0 : i_reg + IDX_W'(1);
                    if (stat.i_last)
                        lvl_reg <= lvl_reg + LW'(1);
                end
            C_DINIT:
            begin
                u_reg   <= NW'(i_reg);
                d_reg   <= '0;
                lvl_reg <= LW'(LV - 1);
            end
            C_DSTEP:
            begin
                if (!stat.a_no)
                begin
                    u_reg <= aq_reg;
                    d_reg <= d_reg + IDX_W'({{IDX_W{1'b0}}, 1'b1} << lvl_reg);
                end
                if (!stat.lvl_zero)
                    lvl_reg <= lvl_m1;
            end
            C_DWR:
                i_reg <= stat.i_last ? '0 : i_reg + IDX_W'(1);
            C_QCHK:
                if (!stat.built)
                    rs_reg <= STAT_NOBLD;
                else if (stat.bad)
                    rs_reg <= STAT_RANGE;
            C_QDA:
                du_reg <= dq_reg;
            C_QDB:
            begin
                lvl_reg <= '0;
                if (du_reg < dq_reg)
                begin
                    u_reg    <= NW'(item_reg.second_index[IDX_W-1:0]);
                    v_reg    <= NW'(item_reg.first_index[IDX_W-1:0]);
                    diff_reg <= {1'b0, dq_reg} - {1'b0, du_reg};
                end
                else
                begin
                    u_reg    <= NW'(item_reg.first_index[IDX_W-1:0]);
                    v_reg    <= NW'(item_reg.second_index[IDX_W-1:0]);
                    diff_reg <= {1'b0, du_reg} - {1'b0, dq_reg};
                end
            end
            C_QUP:
                if (!stat.diff_bit && !stat.lvl_last)
                    lvl_reg <= lvl_reg + LW'(1);
            C_QUPW:
            begin
                u_reg <= aq_reg;
                if (!stat.lvl_last)
                    lvl_reg <= lvl_reg + LW'(1);
            end
            C_QEQ:
            begin
                res_reg <= u_reg;
                lvl_reg <= LW'(LV - 1);
            end
            C_QLV:
                au_reg <= aq_reg;
            C_QLC:
            begin
                if (au_reg != aq_reg)
                begin
                    u_reg <= au_reg;
                    v_reg <= aq_reg;
                end
                if (!stat.lvl_zero)
                    lvl_reg <= lvl_m1;
            end
            C_QLR:
                res_reg <= aq_reg;
            C_QVW:
            begin
                rv_reg <= 32'(vq_reg);
                rp_reg <= 10'(res_reg[IDX_W-1:0]);
            end
            C_OUT:
            begin
                rsp_reg.min_value    <= rv_reg;
                rsp_reg.min_position <= rp_reg;
                rsp_reg.status       <= rs_reg;
            end
            default: ;
        endcase
    end

endmodule

// ----- src/rmq_ctrl.sv -----
// ---------------------------------------------------------------------------
// rmq_ctrl
// Sequencer for load, build and query items; owns the result valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "range_minimum_query_assert.svh"

module rmq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic [1:0]     req_op,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    input  rmq_pkg::stat_t stat,
    output rmq_pkg::cmd_t  cmd
);
    import rmq_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE, ST_LOAD, ST_BINIT,
        ST_TRD, ST_TVI, ST_TCHK, ST_TPRD, ST_TLINK, ST_TPUSH,
        ST_A0RD, ST_A0WR, ST_AJRD1, ST_AJRD2, ST_AJWR,
        ST_DINIT, ST_DRD, ST_DSTEP, ST_DWR,
        ST_QCHK, ST_QDA, ST_QDB, ST_QUP, ST_QUPW, ST_QEQ,
        ST_QLU, ST_QLV, ST_QLC, ST_QLP, ST_QLR, ST_QVAL, ST_QVW,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign req_stall = state_reg != ST_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign out_free  = !(rsp_valid_reg && rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        cmd        = C_NOP;
        case (state_reg)
            ST_IDLE:
                if (req_valid)
                begin
                    cmd = C_TAKE;
                    case (req_op)
                        OP_LOAD:  state_next = ST_LOAD;
                        OP_BUILD: state_next = ST_BINIT;
                        OP_QUERY: state_next = ST_QCHK;
                        default:  state_next = ST_OUT;
                    endcase
                end
            ST_LOAD:  begin cmd = C_LOAD;  state_next = ST_OUT;   end
            ST_BINIT: begin cmd = C_BINIT; state_next = ST_TRD;   end
            ST_TRD:   begin cmd = C_TRD;   state_next = ST_TVI;   end
            ST_TVI:   begin cmd = C_TVI;   state_next = ST_TCHK;  end
            ST_TCHK:
            begin
                cmd        = C_TCHK;
                state_next = stat.pop_go ? ST_TPRD : ST_TLINK;
            end
            ST_TPRD:  begin cmd = C_TPRD;  state_next = ST_TCHK;  end
            ST_TLINK: begin cmd = C_TLINK; state_next = ST_TPUSH; end
            ST_TPUSH:
            begin
                cmd        = C_TPUSH;
                state_next = stat.i_last ? ST_A0RD : ST_TRD;
            end
            ST_A0RD:  begin cmd = C_A0RD;  state_next = ST_A0WR;  end
            ST_A0WR:
            begin
                cmd        = C_A0WR;
                state_next = stat.i_last ? ST_AJRD1 : ST_A0RD;
            end
            ST_AJRD1: begin cmd = C_AJRD1; state_next = ST_AJRD2; end
            ST_AJRD2:
            begin
                cmd = C_AJRD2;
                if (!stat.a_no)
                    state_next = ST_AJWR;
                else if (stat.i_last && stat.lvl_last)
                    state_next = ST_DINIT;
                else
                    state_next = ST_AJRD1;
            end
            ST_AJWR:
            begin
                cmd        = C_AJWR;
                state_next = (stat.i_last && stat.lvl_last) ? ST_DINIT : ST_AJRD1;
            end
            ST_DINIT: begin cmd = C_DINIT; state_next = ST_DRD;   end
            ST_DRD:   begin cmd = C_DRD;   state_next = ST_DSTEP; end
            ST_DSTEP:
            begin
                cmd        = C_DSTEP;
                state_next = stat.lvl_zero ? ST_DWR : ST_DRD;
            end
            ST_DWR:
            begin
                cmd        = C_DWR;
                state_next = stat.i_last ? ST_OUT : ST_DINIT;
            end
            ST_QCHK:
            begin
                cmd        = C_QCHK;
                state_next = (!stat.built || stat.bad) ? ST_OUT : ST_QDA;
            end
            ST_QDA:   begin cmd = C_QDA;   state_next = ST_QDB;   end
            ST_QDB:   begin cmd = C_QDB;   state_next = ST_QUP;   end
            ST_QUP:
            begin
                cmd = C_QUP;
                if (stat.diff_bit)
                    state_next = ST_QUPW;
                else if (stat.lvl_last)
                    state_next = ST_QEQ;
            end
            ST_QUPW:
            begin
                cmd        = C_QUPW;
                state_next = stat.lvl_last ? ST_QEQ : ST_QUP;
            end
            ST_QEQ:
            begin
                cmd        = C_QEQ;
                state_next = stat.uv_eq ? ST_QVAL : ST_QLU;
            end
            ST_QLU:   begin cmd = C_QLU;   state_next = ST_QLV;   end
            ST_QLV:   begin cmd = C_QLV;   state_next = ST_QLC;   end
            ST_QLC:
            begin
                cmd        = C_QLC;
                state_next = stat.lvl_zero ? ST_QLP : ST_QLU;
            end
            ST_QLP:   begin cmd = C_QLP;   state_next = ST_QLR;   end
            ST_QLR:   begin cmd = C_QLR;   state_next = ST_QVAL;  end
            ST_QVAL:  begin cmd = C_QVAL;  state_next = ST_QVW;   end
            ST_QVW:   begin cmd = C_QVW;   state_next = ST_OUT;   end
            ST_OUT:
                if (out_free)
                begin
                    cmd        = C_OUT;
                    state_next = ST_IDLE;
                end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        if (state_reg == ST_OUT && out_free)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `RMQ_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_reg != ST_IDLE)
    `RMQ_ASSERT_IMPL(a_rsp_from_out, $rose(rsp_valid), $past(state_reg == ST_OUT))
    `RMQ_ASSERT_NEXT(a_unbuilt_query, state_reg == ST_QCHK && !stat.built, state_reg == ST_OUT)

endmodule

// ----- src/range_minimum_query.sv -----
// ---------------------------------------------------------------------------
// range_minimum_query
// Range minimum engine: Cartesian tree with binary-lifting ancestor table.
// ---------------------------------------------------------------------------
//  channel | signals                    | direction | transfer
//  req     | req_valid, req_stall, req  | in        | valid & !stall
//  rsp     | rsp_valid, rsp_stall, rsp  | out       | valid & !stall
//  cfg     | cfg_valid, cfg_ready, data | in        | valid & ready
//
//  One item at a time; L = clog2(MAX_ELEMENTS) + 1 ancestor levels. A load,
//  an unused op or a query with an error status goes straight to the result;
//  else a query walks the ancestor table. A build makes the Cartesian tree,
//  then fills the ancestor table level by level and the depth of each of
//  the n = element_count elements. Reset needs no clearing pass; the result
//  register frees the input side while a result waits under rsp_stall.
`timescale 1ns / 1ps

module range_minimum_query #(
    parameter int MAX_ELEMENTS = rmq_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_WIDTH  = rmq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    input  rmq_pkg::req_t             req,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    output rmq_pkg::rsp_t             rsp,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rmq_pkg::CFG_W-1:0] cfg_data
);
    import rmq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    rmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_op    (req.op),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    rmq_dpath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .stat     (stat),
        .rsp      (rsp)
    );

endmodule
